>>> design/lzwhd_pkg.sv
// shared constants and controller/datapath interface types for the hashed-dictionary lzw unit
`default_nettype none

package lzwhd_pkg;

    // default sizing
    localparam int MAX_CODES_DEF   = 4096;
    localparam int TABLE_SLOTS_DEF = 8192;

    // code space
    localparam int CODE_EOF    = 256;
    localparam int FIRST_FREE  = 257;

    // result field widths
    localparam int OUT_CODE_W  = 12;
    localparam int OUT_WIDTH_W = 4;

    // code width limits
    localparam logic [OUT_WIDTH_W-1:0] START_WIDTH = 4'd9;
    localparam logic [OUT_WIDTH_W-1:0] WIDTH_LIMIT = 4'd15;

    // epoch tag width for lazy dictionary invalidation
    localparam int EPOCH_W = 4;

    // request kinds carried on tuser
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOS  = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;          // capture accepted request
        logic first_byte;    // byte starts a new string
        logic probe_start;   // probe address <= home slot
        logic probe_next;    // advance to next slot
        logic hit_take;      // prefix <= code found in slot
        logic miss;          // emit prefix, maybe insert, prefix <= byte
        logic miss_free;     // a free slot sits at the probe address
        logic emit_pending;  // emit pending prefix at end of stream
        logic emit_eof;      // emit eof code and restart stream state
        logic clr_step;      // clear one slot tag
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_eos;
        logic have_prefix;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic out_free;
        logic clr_last;
        logic epoch_last;
    } stat_t;

endpackage

`default_nettype wire

>>> design/lzwhd_ctrl.sv
// controller state machine for the hashed-dictionary lzw unit
`default_nettype none

module lzwhd_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire lzwhd_pkg::stat_t stat,
    output lzwhd_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_MISS,
        ST_EOS_PREFIX,
        ST_EOS_CODE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   free_reg;
    logic   free_next;

    always_comb
    begin
        state_next = state_reg;
        free_next  = free_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.is_eos)
                begin
                    state_next = stat.have_prefix ? ST_EOS_PREFIX : ST_EOS_CODE;
                end
                else if (!stat.have_prefix)
                begin
                    cmd.first_byte = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.probe_start = 1'b1;
                    state_next      = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD:
            begin
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                if (stat.slot_empty)
                begin
                    free_next  = 1'b1;
                    state_next = ST_MISS;
                end
                else if (stat.slot_match)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (stat.probe_last)
                begin
                    free_next  = 1'b0;
                    state_next = ST_MISS;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_PROBE_RD;
                end
            end
            ST_MISS:
            begin
                if (stat.out_free)
                begin
                    cmd.miss      = 1'b1;
                    cmd.miss_free = free_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_EOS_PREFIX:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_pending = 1'b1;
                    state_next       = ST_EOS_CODE;
                end
            end
            ST_EOS_CODE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_eof = 1'b1;
                    state_next   = stat.epoch_last ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            free_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
        end
    end

endmodule

`default_nettype wire

>>> design/lzwhd_datapath.sv
// datapath for the hashed-dictionary lzw unit: string state, dictionary memory, result register
`default_nettype none

module lzwhd_datapath
#(
    parameter int MAX_CODES   = lzwhd_pkg::MAX_CODES_DEF,
    parameter int TABLE_SLOTS = lzwhd_pkg::TABLE_SLOTS_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_type,
    input  wire logic [7:0]                           byte_in,
    input  wire lzwhd_pkg::cmd_t                      cmd,
    output lzwhd_pkg::stat_t                          stat,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [lzwhd_pkg::OUT_CODE_W-1:0]          out_code,
    output logic [lzwhd_pkg::OUT_WIDTH_W-1:0]         out_width,
    output logic                                      out_last
);

    localparam int CODE_W = $clog2(MAX_CODES);
    localparam int NFC_W  = CODE_W + 1;
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int HASH_W = CODE_W + 8;
    localparam int EP_W   = lzwhd_pkg::EPOCH_W;
    localparam int OC_W   = lzwhd_pkg::OUT_CODE_W;
    localparam int OW_W   = lzwhd_pkg::OUT_WIDTH_W;

    typedef struct packed {
        logic [EP_W-1:0]   tag;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] prefix;
        logic [7:0]        data_byte;
    } slot_t;

    slot_t dict_mem [TABLE_SLOTS];

    logic              eos_reg;
    logic [7:0]        byte_reg;
    logic [CODE_W-1:0] prefix_reg,  prefix_next;
    logic              have_reg,    have_next;
    logic [NFC_W-1:0]  nfc_reg,     nfc_next;
    logic [OW_W-1:0]   width_reg,   width_next;
    logic [EP_W-1:0]   epoch_reg,   epoch_next;
    logic [SLOT_W-1:0] paddr_reg,   paddr_next;
    logic [SLOT_W-1:0] pcnt_reg,    pcnt_next;
    logic [SLOT_W-1:0] caddr_reg;
    slot_t             rd_slot_reg;
    logic              ovalid_reg,  ovalid_next;
    logic [OC_W-1:0]   ocode_reg;
    logic [OW_W-1:0]   owidth_reg;
    logic              olast_reg;

    logic [HASH_W-1:0]      hash_full;
    logic [CODE_W+OC_W-1:0] prefix_ext;
    logic [NFC_W-1:0]       nfc_inc;
    logic                   room;
    logic                   grow;
    logic                   do_insert;
    logic                   emit;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    slot_t                  wr_data;

    assign hash_full  = {prefix_reg, byte_reg};
    assign prefix_ext = {{OC_W{1'b0}}, prefix_reg};
    assign nfc_inc    = nfc_reg + NFC_W'(1);
    assign room       = nfc_reg < NFC_W'(MAX_CODES);
    assign grow       = (width_reg < lzwhd_pkg::WIDTH_LIMIT) && ((nfc_inc >> width_reg) != '0);
    assign do_insert  = cmd.miss && cmd.miss_free && room;
    assign emit       = cmd.miss || cmd.emit_pending || cmd.emit_eof;

    // status
    assign stat.is_eos      = (eos_reg == lzwhd_pkg::REQ_EOS);
    assign stat.have_prefix = have_reg;
    assign stat.slot_empty  = (rd_slot_reg.tag != epoch_reg);
    assign stat.slot_match  = (rd_slot_reg.prefix == prefix_reg)
                              && (rd_slot_reg.data_byte == byte_reg);
    assign stat.probe_last  = (pcnt_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign stat.out_free    = !ovalid_reg || out_ready;
    assign stat.clr_last    = (caddr_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign stat.epoch_last  = (epoch_reg == {EP_W{1'b1}});

    // string and code state
    always_comb
    begin
        prefix_next = prefix_reg;
        have_next   = have_reg;
        nfc_next    = nfc_reg;
        width_next  = width_reg;
        epoch_next  = epoch_reg;
        paddr_next  = paddr_reg;
        pcnt_next   = pcnt_reg;
        if (cmd.first_byte)
        begin
            prefix_next = CODE_W'(byte_reg);
            have_next   = 1'b1;
        end
        if (cmd.probe_start)
        begin
            paddr_next = hash_full[SLOT_W-1:0];
            pcnt_next  = '0;
        end
        if (cmd.probe_next)
        begin
            paddr_next = paddr_reg + SLOT_W'(1);
            pcnt_next  = pcnt_reg + SLOT_W'(1);
        end
        if (cmd.hit_take)
        begin
            prefix_next = rd_slot_reg.code;
        end
        if (cmd.miss)
        begin
            prefix_next = CODE_W'(byte_reg);
        end
        if (do_insert)
        begin
            nfc_next = nfc_inc;
            if (grow)
            begin
                width_next = width_reg + OW_W'(1);
            end
        end
        if (cmd.emit_eof)
        begin
            prefix_next = '0;
            have_next   = 1'b0;
            nfc_next    = NFC_W'(lzwhd_pkg::FIRST_FREE);
            width_next  = lzwhd_pkg::START_WIDTH;
            epoch_next  = epoch_reg + EP_W'(1);
        end
        if (cmd.clr_step && stat.clr_last)
        begin
            epoch_next = EP_W'(1);
        end
    end

    // result register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            have_reg   <= 1'b0;
            nfc_reg    <= NFC_W'(lzwhd_pkg::FIRST_FREE);
            width_reg  <= lzwhd_pkg::START_WIDTH;
            epoch_reg  <= '0;
            caddr_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            have_reg   <= have_next;
            nfc_reg    <= nfc_next;
            width_reg  <= width_next;
            epoch_reg  <= epoch_next;
            ovalid_reg <= ovalid_next;
            if (cmd.clr_step)
            begin
                caddr_reg <= caddr_reg + SLOT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        paddr_reg <= paddr_next;
        pcnt_reg  <= pcnt_next;
        if (cmd.load)
        begin
            eos_reg  <= req_type;
            byte_reg <= byte_in;
        end
        if (emit)
        begin
            ocode_reg  <= cmd.emit_eof ? OC_W'(lzwhd_pkg::CODE_EOF) : prefix_ext[OC_W-1:0];
            owidth_reg <= width_reg;
            olast_reg  <= cmd.emit_eof;
        end
    end

    // dictionary memory, one write and one registered read port
    always_comb
    begin
        wr_en   = cmd.clr_step || do_insert;
        wr_addr = cmd.clr_step ? caddr_reg : paddr_reg;
        wr_data = '0;
        if (!cmd.clr_step)
        begin
            wr_data.tag       = epoch_reg;
            wr_data.code      = nfc_reg[CODE_W-1:0];
            wr_data.prefix    = prefix_reg;
            wr_data.data_byte = byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dict_mem[wr_addr] <= wr_data;
        end
        rd_slot_reg <= dict_mem[paddr_reg];
    end

    assign out_valid = ovalid_reg;
    assign out_code  = ocode_reg;
    assign out_width = owidth_reg;
    assign out_last  = olast_reg;

endmodule

`default_nettype wire

>>> design/lzw_compressor_hashed_dict_unit.sv
// top level of the lzw compressor with a hashed, linearly probed dictionary
`default_nettype none

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] byte_in, tuser[0] req_type
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata[11:0] out_code, [15:12] out_width,
//                                               tlast end_of_run
//
// a data byte that opens a string passes through dispatch alone; a hit adds the probe
// read and check, a miss also the miss state, and each extra probe repeats both, as
// the dictionary read is registered; end of stream emits any pending prefix, then the
// eof code, each after any wait on the result register; after reset, and after every
// 15th end of stream, a clearing pass resets the slot tags while s_axis_tready is low
// a result waits in a one-deep register; the controller stalls only when it must
// emit a second result while the first is still untaken

module lzw_compressor_hashed_dict_unit
#(
    parameter int MAX_CODES   = lzwhd_pkg::MAX_CODES_DEF,
    parameter int TABLE_SLOTS = lzwhd_pkg::TABLE_SLOTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // byte_in
    input  wire logic [0:0]  s_axis_tuser,   // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_code, out_width
    output logic             m_axis_tlast    // end_of_run
);

    lzwhd_pkg::cmd_t  cmd;
    lzwhd_pkg::stat_t stat;

    logic [lzwhd_pkg::OUT_CODE_W-1:0]  out_code;
    logic [lzwhd_pkg::OUT_WIDTH_W-1:0] out_width;

    // control: one request at a time through the probe sequence
    lzwhd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // string state, dictionary and result register
    lzwhd_datapath
    #(
        .MAX_CODES   (MAX_CODES),
        .TABLE_SLOTS (TABLE_SLOTS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_type  (s_axis_tuser[0]),
        .byte_in   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_code  (out_code),
        .out_width (out_width),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_width, out_code};

`ifndef ASSERT_OFF
    // a result is only loaded when the result register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.miss || cmd.emit_pending || cmd.emit_eof) |-> stat.out_free)
        else $error("result register overwritten");

    // at most one emit command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.miss, cmd.emit_pending, cmd.emit_eof}))
        else $error("conflicting emit commands");

    // the stream end marker only ever carries the eof code
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast)
            |-> (m_axis_tdata[11:0] == 12'(lzwhd_pkg::CODE_EOF)))
        else $error("end of run without eof code");

    // no request taken while the dictionary is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !s_axis_tready)
        else $error("request accepted during clearing pass");
`endif

endmodule

`default_nettype wire

>>> tb/lzw_compressor_hashed_dict_unit_tb.sv
// self-checking testbench for the hashed-dictionary lzw compressor unit
module lzw_compressor_hashed_dict_unit_tb;
    import lzwhd_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 9;
    localparam int DICT_SLOTS       = TABLE_SLOTS_DEF;
    localparam int CODE_LIMIT       = MAX_CODES_DEF;
    // enough random bytes in one stream to take the width past 10 bits
    localparam int LONG_STREAM_LEN  = 850;
    localparam int PHASE_QUOTA      = 220;
    localparam int HOLD_CYCLES      = 500;
    // after the last expected code, keep watching for strays
    localparam int DRAIN_CYCLES     = 40;
    // limit for the slowest run, clearing passes included
    localparam int RUN_LIMIT_CYCLES = 1_500_000;

    // one emitted code as it leaves the block
    typedef struct packed {
        logic [OUT_CODE_W-1:0]  code;
        logic [OUT_WIDTH_W-1:0] width;
        logic                   last;
    } lzw_code_t;

    // one row of the directed table; typed rows carry their own results
    typedef struct packed {
        logic       req;
        logic [7:0] data;
        logic       typed;
        logic [1:0] n;
        lzw_code_t  r0;
        lzw_code_t  r1;
    } dir_row_t;

    localparam lzw_code_t NO_CODE  = '0;
    localparam lzw_code_t EOF_AT_9 = '{OUT_CODE_W'(CODE_EOF), START_WIDTH, 1'b1};

    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        // empty stream right after reset
        '{REQ_EOS,  8'h00, 1'b1, 2'd1, EOF_AT_9, NO_CODE},
        // single top byte, then flush
        '{REQ_DATA, 8'hFF, 1'b1, 2'd0, NO_CODE, NO_CODE},
        '{REQ_EOS,  8'h00, 1'b1, 2'd2, '{12'd255, START_WIDTH, 1'b0}, EOF_AT_9},
        // run of zeros: first miss, then growing hits
        '{REQ_DATA, 8'h00, 1'b1, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'h00, 1'b1, 2'd1, '{12'd0, START_WIDTH, 1'b0}, NO_CODE},
        '{REQ_DATA, 8'h00, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'h00, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'h00, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'h00, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'h00, 1'b0, 2'd0, NO_CODE, NO_CODE},
        // ff/ff lands on the last slot of the table
        '{REQ_DATA, 8'hFF, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'hFF, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'h00, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'hFF, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'h55, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'hAA, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_EOS,  8'hFF, 1'b0, 2'd0, NO_CODE, NO_CODE},
        // fresh stream after flush: state back to start
        '{REQ_DATA, 8'hAA, 1'b0, 2'd0, NO_CODE, NO_CODE},
        '{REQ_DATA, 8'h55, 1'b1, 2'd1, '{12'h0AA, START_WIDTH, 1'b0}, NO_CODE},
        '{REQ_EOS,  8'h00, 1'b1, 2'd2, '{12'h055, START_WIDTH, 1'b0}, EOF_AT_9},
        '{REQ_EOS,  8'hFF, 1'b1, 2'd1, EOF_AT_9, NO_CODE}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // byte_in
    logic [0:0]  s_axis_tuser  = '0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // out_code, out_width
    logic        m_axis_tlast;         // end_of_run

    // dictionary image and string state of the encoder
    bit          dict_used   [DICT_SLOTS];
    int unsigned dict_code   [DICT_SLOTS];
    int unsigned dict_prefix [DICT_SLOTS];
    int unsigned dict_byte   [DICT_SLOTS];
    int unsigned str_prefix;
    bit          str_open;
    int unsigned free_code;
    logic [OUT_WIDTH_W-1:0] cur_width;

    lzw_code_t pending_codes [$];
    int        code_errors = 0;
    int        items_sent  = 0;

    // traffic shaping, written by the main process only
    int idle_pct    = 0;
    int stall_pct   = 0;
    bit hold_toggle = 1'b0;

    // receiver-side hold bookkeeping
    bit hold_seen = 1'b0;
    int hold_left = 0;

    lzw_compressor_hashed_dict_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // empty dictionary, no open string, codes and width back at the start
    function automatic void dict_clear();
        for (int i = 0; i < DICT_SLOTS; i++)
        begin
            dict_used[i] = 1'b0;
        end
        str_prefix = 0;
        str_open   = 1'b0;
        free_code  = FIRST_FREE;
        cur_width  = START_WIDTH;
    endfunction

    // encode one request, return how many codes it emits
    function automatic int lzw_encode_step(input logic req, input logic [7:0] b,
                                           output lzw_code_t res [2]);
        int unsigned pos;
        int unsigned found   = 0;
        int unsigned free_at = 0;
        bit          hit     = 1'b0;
        bit          free_ok = 1'b0;
        int          cnt     = 0;
        res[0] = NO_CODE;
        res[1] = NO_CODE;
        if (req == REQ_EOS)
        begin
            // flush the pending string, then the end marker at the current width
            if (str_open)
            begin
                res[cnt] = '{OUT_CODE_W'(str_prefix), cur_width, 1'b0};
                cnt++;
            end
            res[cnt] = '{OUT_CODE_W'(CODE_EOF), cur_width, 1'b1};
            cnt++;
            dict_clear();
            return cnt;
        end
        if (!str_open)
        begin
            // first byte opens the string, nothing leaves
            str_prefix = 32'(b);
            str_open   = 1'b1;
            return 0;
        end
        // linear probe from the home slot, wrapping round the table
        pos = ((str_prefix & 32'hFFFF) * 256 + b) % DICT_SLOTS;
        for (int n = 0; n < DICT_SLOTS && !hit && !free_ok; n++)
        begin
            if (!dict_used[pos])
            begin
                free_ok = 1'b1;
                free_at = pos;
            end
            else if (dict_prefix[pos] == str_prefix && dict_byte[pos] == b)
            begin
                hit   = 1'b1;
                found = dict_code[pos];
            end
            else
            begin
                pos = (pos + 1) % DICT_SLOTS;
            end
        end
        if (hit)
        begin
            str_prefix = found;
            return 0;
        end
        // miss: emit the string, learn the extension while codes remain
        res[cnt] = '{OUT_CODE_W'(str_prefix), cur_width, 1'b0};
        cnt++;
        if (free_code < CODE_LIMIT && free_ok)
        begin
            dict_used[free_at]   = 1'b1;
            dict_code[free_at]   = free_code;
            dict_prefix[free_at] = str_prefix;
            dict_byte[free_at]   = 32'(b);
            free_code++;
            if (cur_width < WIDTH_LIMIT && free_code >= (32'd1 << cur_width))
            begin
                cur_width++;
            end
        end
        str_prefix = 32'(b);
        return cnt;
    endfunction

    // drive one request at the falling edge, wait for its handshake, log its codes
    task automatic offer_request(input dir_row_t row);
        lzw_code_t res [2];
        int        n;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.data;
        s_axis_tuser  <= row.req;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        n = lzw_encode_step(row.req, row.data, res);
        if (row.typed)
        begin
            // hand-written rows trust the table, the encoder only keeps state
            for (int i = 0; i < row.n; i++)
            begin
                pending_codes.push_back(i == 0 ? row.r0 : row.r1);
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                pending_codes.push_back(res[i]);
            end
        end
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        offer_request('{REQ_DATA, b, 1'b0, 2'd0, NO_CODE, NO_CODE});
    endtask

    task automatic send_eos();
        offer_request('{REQ_EOS, 8'($urandom_range(255)), 1'b0, 2'd0, NO_CODE, NO_CODE});
    endtask

    // one stream closed by end of stream; style sets how repetitive the bytes are
    task automatic send_stream(input int len, input int style);
        logic [7:0] alphabet [4];
        logic [7:0] run_byte;
        for (int k = 0; k < 4; k++)
        begin
            alphabet[k] = 8'($urandom_range(255));
        end
        run_byte = 8'($urandom_range(255));
        repeat (len)
        begin
            case (style)
                0: send_byte(8'($urandom_range(255)));
                1: send_byte(alphabet[2'($urandom_range(3))]);
                default:
                begin
                    // long runs of one byte with an occasional switch
                    if ($urandom_range(7) == 0)
                    begin
                        run_byte = 8'($urandom_range(255));
                    end
                    send_byte(run_byte);
                end
            endcase
        end
        send_eos();
    endtask

    task automatic run_phase(input int idle, input int stall, input int quota);
        int stop_at;
        int len;
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = items_sent + quota;
        while (items_sent < stop_at)
        begin
            // mostly short streams, some longer ones, now and then an empty one
            if ($urandom_range(15) == 0)
                len = 0;
            else if ($urandom_range(9) == 0)
                len = $urandom_range(300);
            else
                len = $urandom_range(40);
            send_stream(len, $urandom_range(2));
        end
    endtask

    // receiver: random stalls, plus a long hold-off when the main process asks
    always @(negedge clk)
    begin
        if (hold_seen != hold_toggle)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result checker: every accepted code against the oldest expectation
    always @(posedge clk)
    begin
        lzw_code_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("unexpected result: out_code %0d out_width %0d end_of_run %0b",
                       m_axis_tdata[OUT_CODE_W-1:0], m_axis_tdata[OUT_CODE_W +: OUT_WIDTH_W],
                       m_axis_tlast);
                code_errors++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (m_axis_tdata[OUT_CODE_W-1:0] !== want.code)
                begin
                    $error("out_code: expected %0d, got %0d",
                           want.code, m_axis_tdata[OUT_CODE_W-1:0]);
                    code_errors++;
                end
                if (m_axis_tdata[OUT_CODE_W +: OUT_WIDTH_W] !== want.width)
                begin
                    $error("out_width: expected %0d, got %0d",
                           want.width, m_axis_tdata[OUT_CODE_W +: OUT_WIDTH_W]);
                    code_errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("end_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
                    code_errors++;
                end
            end
        end
    end

    initial
    begin
        dict_clear();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; the block runs its clearing pass first, handshake waits it out
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            offer_request(DIRECTED_ROWS[r]);
        end

        // one long incompressible stream: width climbs to 11 bits
        repeat (LONG_STREAM_LEN)
        begin
            send_byte(8'($urandom_range(255)));
        end
        send_eos();

        // random streams under each traffic pattern
        run_phase(0, 0, PHASE_QUOTA);
        run_phase(80, 0, PHASE_QUOTA);
        // long receiver hold-off while requests keep coming, to back up the input
        hold_toggle = ~hold_toggle;
        run_phase(0, 80, PHASE_QUOTA);
        run_phase(9, 9, PHASE_QUOTA);

        s_axis_tvalid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        while (pending_codes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (code_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
